>>> rtl/core/mss_pkg.sv
package mss_pkg;
	localparam int MaxPointsDef = 256;
	localparam int SumW = 27;
	localparam int TotW = 9;
	localparam int CoordW = 16;
	localparam int DistW = 35;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
	localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
endpackage

>>> rtl/core/mss_isqrt.sv
module mss_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [mss_pkg::DistW-1:0] val,
	output logic done,
	output logic [17:0] root
);
	import mss_pkg::*;

	logic [DistW:0] rem_q;
	logic [17:0] res_q;
	logic [4:0] step_q;
	logic run_q;
	logic [DistW:0] trial;
	logic [DistW:0] bitv;

	// One result bit per cycle, most significant first.
	always_comb begin
		bitv = '0;
		bitv[{step_q, 1'b0}] = 1'b1;
		trial = ({{(DistW - 17){1'b0}}, res_q} << (step_q + 5'd1)) + bitv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				step_q <= 5'd17;
			end else if (run_q) begin
				if (step_q == 5'd0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, val};
			res_q <= '0;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q[step_q] <= 1'b1;
			end
		end
	end

	assign root = res_q;
endmodule

>>> rtl/core/mirror_symmetry_score_top.sv
// Mirror symmetry scorer.
// A point request is taken when start is high and busy is low. Each point is
// written to an on-chip store of MAX_POINTS entries; points past capacity are
// dropped and flagged. The point with last_point set starts scoring: each
// stored point is mirrored across x=0, y=0 and z=0 in turn, and the store is
// walked once per mirrored point through its single read port to find the
// nearest squared distance, whose integer square root is then taken by a
// bit-serial unit. Busy stays high while scoring; a plain point leaves it low.
// The result appears on symmetry_sum, point_total and overflow for one cycle
// with valid high; the receiver cannot stall it. Reset clears the point count
// and the drop flag; store contents need no reset.
module mirror_symmetry_score_top #(
	parameter int MAX_POINTS = mss_pkg::MaxPointsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [mss_pkg::CoordW-1:0] point_x,
	input  logic signed [mss_pkg::CoordW-1:0] point_y,
	input  logic signed [mss_pkg::CoordW-1:0] point_z,
	input  logic last_point,
	output logic valid,
	output logic [mss_pkg::SumW-1:0] symmetry_sum,
	output logic [mss_pkg::TotW-1:0] point_total,
	output logic overflow
);
	import mss_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LDI  = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [3*CoordW-1:0] mem [MAX_POINTS];
	logic [3*CoordW-1:0] rd_s1;
	logic [AW-1:0] raddr;
	logic [CW-1:0] count_q, i_q, j_q;
	logic drop_q;
	logic [1:0] axis_q;
	logic jv_s1, jfirst_s1, jlast_s1;
	logic signed [CoordW:0] mx_q, my_q, mz_q;
	logic [DistW-1:0] best_q, dist_s2;
	logic v_s2, first_s2, last_s2;
	logic [SumW+8:0] sum_q;
	logic sq_go, sq_done;
	logic [17:0] root;
	logic accept;
	logic signed [CoordW:0] dx, dy, dz;
	logic [CoordW:0] ax, ay, az;
	logic [2*CoordW+1:0] sqx, sqy, sqz;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		raddr = i_q[AW-1:0];
		if (state_q == ST_SCAN) raddr = j_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && count_q < CW'(MAX_POINTS))
			mem[count_q[AW-1:0]] <= {point_x, point_y, point_z};
		rd_s1 <= mem[raddr];
	end

	always_comb begin
		dx = mx_q - {rd_s1[47], rd_s1[47:32]};
		dy = my_q - {rd_s1[31], rd_s1[31:16]};
		dz = mz_q - {rd_s1[15], rd_s1[15:0]};
		ax = dx[CoordW] ? (CoordW+1)'(0) - dx : dx;
		ay = dy[CoordW] ? (CoordW+1)'(0) - dy : dy;
		az = dz[CoordW] ? (CoordW+1)'(0) - dz : dz;
		sqx = ax * ax;
		sqy = ay * ay;
		sqz = az * az;
	end

	always_ff @(posedge clk) begin
		dist_s2 <= DistW'(sqx) + DistW'(sqy) + DistW'(sqz);
		if (v_s2 && (first_s2 || dist_s2 < best_q)) best_q <= dist_s2;
	end

	assign sq_go = (state_q == ST_SCAN) && v_s2 && last_s2;

	mss_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sq_go),
		.val((first_s2 || dist_s2 < best_q) ? dist_s2 : best_q),
		.done(sq_done), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q <= 1'b0;
			valid <= 1'b0;
			jv_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			valid <= 1'b0;
			jv_s1 <= 1'b0;
			v_s2 <= jv_s1;
			first_s2 <= jfirst_s1;
			last_s2 <= jlast_s1;
			case (state_q)
				ST_IDLE: if (accept) begin
					if (count_q < CW'(MAX_POINTS)) count_q <= count_q + 1'b1;
					else drop_q <= 1'b1;
					if (last_point) begin
						state_q <= ST_LDI;
						i_q <= '0;
						axis_q <= 2'd0;
						sum_q <= '0;
					end
				end
				ST_LDI: begin
					// rd_s1 holds point i next cycle; WAIT forms the mirror for SCAN.
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					mx_q <= (axis_q == 2'd0) ? -{rd_s1[47], rd_s1[47:32]}
						: {rd_s1[47], rd_s1[47:32]};
					my_q <= (axis_q == 2'd1) ? -{rd_s1[31], rd_s1[31:16]}
						: {rd_s1[31], rd_s1[31:16]};
					mz_q <= (axis_q == 2'd2) ? -{rd_s1[15], rd_s1[15:0]}
						: {rd_s1[15], rd_s1[15:0]};
					j_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (j_q < count_q) begin
						jv_s1 <= 1'b1;
						jfirst_s1 <= (j_q == '0);
						jlast_s1 <= (j_q == count_q - 1'b1);
						j_q <= j_q + 1'b1;
					end
					if (sq_go) state_q <= ST_SQRT;
				end
				ST_SQRT: if (sq_done) begin
					sum_q <= sum_q + (SumW+9)'(root);
					if (axis_q == 2'd2) begin
						axis_q <= 2'd0;
						if (i_q == count_q - 1'b1) state_q <= ST_DONE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_LDI;
						end
					end else begin
						axis_q <= axis_q + 1'b1;
						state_q <= ST_LDI;
					end
				end
				ST_DONE: begin
					valid <= 1'b1;
					symmetry_sum <= (sum_q > (SumW+9)'(SumMax)) ? SumMax : sum_q[SumW-1:0];
					point_total <= (count_q > CW'(TotMax)) ? TotMax : TotW'(count_q);
					overflow <= drop_q;
					count_q <= '0;
					drop_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS)) else $error("count over capacity");
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> state_q == ST_IDLE) else $error("valid outside idle");
	a_go: assert property (@(posedge clk) disable iff (!arst_n)
		sq_go |=> state_q == ST_SQRT) else $error("sqrt not entered");
endmodule
